/* hdl/dlmt_pkg.sv */
// ============================================================================
// dlmt_pkg
// Shared types, constants and scanner tables for the longest-match tokenizer.
// ============================================================================
package dlmt_pkg;

  // Lookahead buffer geometry.
  localparam int unsigned LOOKAHEAD_DEPTH = 64;
  localparam int unsigned BUF_AW          = $clog2(LOOKAHEAD_DEPTH);
  localparam int unsigned OCC_W           = BUF_AW + 1;

  // Port field widths.
  localparam int unsigned CH_W    = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned NUM_STATES = 9;

  typedef logic [STATE_W-1:0] dfa_state_t;
  typedef logic [KIND_W-1:0]  kind_t;

  // Special state codes.
  localparam dfa_state_t ST_START  = 4'd0;
  localparam dfa_state_t ST_DEAD   = 4'd15;
  localparam dfa_state_t NO_ACCEPT = 4'd15;
  localparam dfa_state_t ST_LAST   = 4'd8;

  // Token kinds.
  localparam kind_t KIND_NUMBER    = 3'd0;
  localparam kind_t KIND_IDENT     = 3'd1;
  localparam kind_t KIND_SPACE     = 3'd2;
  localparam kind_t KIND_AT        = 3'd3;
  localparam kind_t KIND_UNMATCHED = 3'd4;
  localparam kind_t NO_KIND        = 3'd7;

  // Characters with a role in classification.
  localparam logic [CH_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CH_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CH_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CH_W-1:0] CH_AT        = 8'h40;
  localparam logic [CH_W-1:0] CH_DOT       = 8'h2E;
  localparam logic [CH_W-1:0] CH_UNDER     = 8'h5F;
  localparam logic [CH_W-1:0] CH_LOW_A     = 8'h61;
  localparam logic [CH_W-1:0] CH_LOW_E     = 8'h65;
  localparam logic [CH_W-1:0] CH_LOW_Z     = 8'h7A;
  localparam logic [CH_W-1:0] CH_DIGIT_0   = 8'h30;
  localparam logic [CH_W-1:0] CH_DIGIT_9   = 8'h39;

  // Character class rows of the transition table.
  localparam int unsigned ROW_ALPHA = 0;
  localparam int unsigned ROW_DIGIT = 1;
  localparam int unsigned ROW_E     = 2;
  localparam int unsigned ROW_DOT   = 3;
  localparam int unsigned ROW_AT    = 4;
  localparam int unsigned ROW_BLANK = 5;
  localparam int unsigned ROW_UNDER = 6;
  localparam int unsigned NUM_ROWS  = 7;

  localparam dfa_state_t TRANS [NUM_ROWS][NUM_STATES] = '{
    '{4'd7,  4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd7,  4'd15},
    '{4'd1,  4'd1,  4'd2,  4'd2,  4'd5,  4'd5,  4'd15, 4'd7,  4'd15},
    '{4'd15, 4'd4,  4'd4,  4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15},
    '{4'd3,  4'd2,  4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15},
    '{4'd8,  4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15},
    '{4'd6,  4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd6,  4'd15, 4'd15},
    '{4'd7,  4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd7,  4'd15}
  };

  localparam kind_t ACCEPT_KIND [NUM_STATES] = '{
    NO_KIND, KIND_NUMBER, KIND_NUMBER, NO_KIND, NO_KIND,
    KIND_NUMBER, KIND_SPACE, KIND_IDENT, KIND_AT
  };

  // Token kind of a state, or no kind for a non-accepting or invalid state.
  function automatic kind_t accept_kind_of(dfa_state_t st);
    kind_t k;
    k = NO_KIND;
    if (st <= ST_LAST) begin
      k = ACCEPT_KIND[st];
    end
    return k;
  endfunction

  // Result of one scanner step, passed from the step logic to the sequencer.
  typedef struct packed {
    dfa_state_t nxt_state;
    logic       dead;
    logic       accepting;
    logic       is_newline;
  } step_res_t;

endpackage

/* hdl/dfa_longest_match_tokenizer.sv */
// ============================================================================
// dfa_longest_match_tokenizer
// Longest-match tokenizer over a byte stream, with rewind and replay of the
// buffered bytes from a 64-entry circular lookahead buffer.
// ============================================================================
//
//  Channel | Ports                                              | Direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid, in_stall, in_ch, in_end_of_text          | request in
//  out     | out_valid, out_stall, out_kind, out_start_pos,     | request out
//          | out_length, out_line, out_last_of_run              |
//
//  Each byte takes a write in the idle state, then a buffer read and a
//  transition per scanner step for every byte scanned or rescanned after a
//  rewind, and a last buffer check, then the finish, to close the run. A
//  failed transition spends its read and transition before the rewind; a
//  forced decision spends one read. These steps run one after another on the
//  single buffer read port and the shared step logic.
//  Reset (rst_n low, synchronous) empties the buffer and clears all counters.
//  A stalled output holds its request; scanning goes on while one more token
//  can be held, and the block waits at the next decision until the output
//  register frees.
//
module dfa_longest_match_tokenizer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dlmt_pkg::CH_W-1:0]        in_ch,
  input  logic                             in_end_of_text,
  output logic                             out_valid,
  input  logic                             out_stall,
  output dlmt_pkg::kind_t                  out_kind,
  output logic [dlmt_pkg::POS_W-1:0]       out_start_pos,
  output logic [dlmt_pkg::LEN_W-1:0]       out_length,
  output logic [dlmt_pkg::POS_W-1:0]       out_line,
  output logic                             out_last_of_run
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINISH
  } seq_state_t;

  typedef logic [dlmt_pkg::OCC_W-1:0]  occ_t;
  typedef logic [dlmt_pkg::BUF_AW-1:0] addr_t;
  typedef logic [dlmt_pkg::POS_W-1:0]  pos_t;

  seq_state_t           state_r, state_nxt;
  logic                 flush_r, flush_nxt;
  dlmt_pkg::dfa_state_t dfa_r, dfa_nxt;
  dlmt_pkg::dfa_state_t acc_state_r, acc_state_nxt;
  occ_t                 acc_len_r, acc_len_nxt;
  occ_t                 nl_scan_r, nl_scan_nxt;
  occ_t                 nl_acc_r, nl_acc_nxt;
  occ_t                 occ_r, occ_nxt;
  occ_t                 off_r, off_nxt;
  pos_t                 tok_start_r, tok_start_nxt;
  pos_t                 line_r, line_nxt;

  // Held result and output register.
  logic                 pend_valid_r, pend_valid_nxt;
  dlmt_pkg::kind_t      pend_kind_r, pend_kind_nxt;
  pos_t                 pend_start_r, pend_start_nxt;
  logic [dlmt_pkg::LEN_W-1:0] pend_len_r, pend_len_nxt;
  pos_t                 pend_line_r, pend_line_nxt;

  logic                 out_valid_r, out_valid_nxt;
  dlmt_pkg::kind_t      out_kind_r, out_kind_nxt;
  pos_t                 out_start_r, out_start_nxt;
  logic [dlmt_pkg::LEN_W-1:0] out_len_r, out_len_nxt;
  pos_t                 out_line_r, out_line_nxt;
  logic                 out_last_r, out_last_nxt;

  // Lookahead buffer.
  logic [dlmt_pkg::CH_W-1:0] buf_mem [dlmt_pkg::LOOKAHEAD_DEPTH];
  logic [dlmt_pkg::CH_W-1:0] rd_data_r;
  addr_t                     rd_addr;
  addr_t                     wr_addr;
  logic                      wr_en;

  dlmt_pkg::step_res_t  step;
  logic                 out_free;
  logic                 decide_req;
  logic                 acc_seen;
  dlmt_pkg::kind_t      dec_kind;
  occ_t                 dec_len;
  occ_t                 dec_nl;

  // Buffer addresses follow absolute text positions modulo the depth.
  assign rd_addr = tok_start_r[dlmt_pkg::BUF_AW-1:0] + off_r[dlmt_pkg::BUF_AW-1:0];
  assign wr_addr = tok_start_r[dlmt_pkg::BUF_AW-1:0] + occ_r[dlmt_pkg::BUF_AW-1:0];
  assign wr_en   = (state_r == S_IDLE) && in_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= in_ch;
    end
    if (state_r == S_READ) begin
      rd_data_r <= buf_mem[rd_addr];
    end
  end

  // Shared scanner step on the byte just read.
  dlmt_step u_step (
    .cur_state (dfa_r),
    .ch        (rd_data_r),
    .res       (step)
  );

  // Token decision: last accepting prefix, or one unmatched byte.
  assign acc_seen = (acc_state_r != dlmt_pkg::NO_ACCEPT);
  assign dec_kind = acc_seen ? dlmt_pkg::accept_kind_of(acc_state_r)
                             : dlmt_pkg::KIND_UNMATCHED;
  assign dec_len  = acc_seen ? acc_len_r : occ_t'(1);
  assign dec_nl   = acc_seen ? nl_acc_r : '0;

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    flush_nxt      = flush_r;
    dfa_nxt        = dfa_r;
    acc_state_nxt  = acc_state_r;
    acc_len_nxt    = acc_len_r;
    nl_scan_nxt    = nl_scan_r;
    nl_acc_nxt     = nl_acc_r;
    occ_nxt        = occ_r;
    off_nxt        = off_r;
    tok_start_nxt  = tok_start_r;
    line_nxt       = line_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt  = pend_kind_r;
    pend_start_nxt = pend_start_r;
    pend_len_nxt   = pend_len_r;
    pend_line_nxt  = pend_line_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_start_nxt  = out_start_r;
    out_len_nxt    = out_len_r;
    out_line_nxt   = out_line_r;
    out_last_nxt   = out_last_r;
    decide_req     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          occ_nxt   = occ_r + occ_t'(1);
          flush_nxt = in_end_of_text;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (off_r < occ_r) begin
          state_nxt = S_EVAL;
        end else if (occ_r == '0) begin
          state_nxt = S_FINISH;
        end else if (flush_r || occ_r == occ_t'(dlmt_pkg::LOOKAHEAD_DEPTH)) begin
          decide_req = 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_EVAL: begin
        if (step.dead) begin
          decide_req = 1'b1;
        end else begin
          dfa_nxt     = step.nxt_state;
          off_nxt     = off_r + occ_t'(1);
          nl_scan_nxt = nl_scan_r + occ_t'(step.is_newline);
          if (step.accepting) begin
            acc_state_nxt = step.nxt_state;
            acc_len_nxt   = off_r + occ_t'(1);
            nl_acc_nxt    = nl_scan_r + occ_t'(step.is_newline);
          end
          state_nxt = S_READ;
        end
      end
      S_FINISH: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = pend_kind_r;
            out_start_nxt  = pend_start_r;
            out_len_nxt    = pend_len_r;
            out_line_nxt   = pend_line_r;
            out_last_nxt   = 1'b1;
            pend_valid_nxt = 1'b0;
          end
          // End of text starts a fresh text at position zero.
          if (flush_r) begin
            tok_start_nxt = '0;
            line_nxt      = '0;
            dfa_nxt       = dlmt_pkg::ST_START;
            acc_state_nxt = dlmt_pkg::NO_ACCEPT;
            off_nxt       = '0;
            occ_nxt       = '0;
            nl_scan_nxt   = '0;
            nl_acc_nxt    = '0;
            flush_nxt     = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Emit a token: the held result moves out, the new one is held until the
    // next token or the end of the run tells whether it is the last.
    if (decide_req && (!pend_valid_r || out_free)) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = pend_kind_r;
        out_start_nxt = pend_start_r;
        out_len_nxt   = pend_len_r;
        out_line_nxt  = pend_line_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_kind_nxt  = dec_kind;
      pend_start_nxt = tok_start_r;
      pend_len_nxt   = dlmt_pkg::LEN_W'(dec_len);
      pend_line_nxt  = line_r;
      line_nxt       = line_r + pos_t'(dec_nl);
      tok_start_nxt  = tok_start_r + pos_t'(dec_len);
      occ_nxt        = occ_r - dec_len;
      off_nxt        = '0;
      dfa_nxt        = dlmt_pkg::ST_START;
      acc_state_nxt  = dlmt_pkg::NO_ACCEPT;
      acc_len_nxt    = '0;
      nl_scan_nxt    = '0;
      nl_acc_nxt     = '0;
      state_nxt      = S_READ;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      flush_r      <= 1'b0;
      dfa_r        <= dlmt_pkg::ST_START;
      acc_state_r  <= dlmt_pkg::NO_ACCEPT;
      acc_len_r    <= '0;
      nl_scan_r    <= '0;
      nl_acc_r     <= '0;
      occ_r        <= '0;
      off_r        <= '0;
      tok_start_r  <= '0;
      line_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flush_r      <= flush_nxt;
      dfa_r        <= dfa_nxt;
      acc_state_r  <= acc_state_nxt;
      acc_len_r    <= acc_len_nxt;
      nl_scan_r    <= nl_scan_nxt;
      nl_acc_r     <= nl_acc_nxt;
      occ_r        <= occ_nxt;
      off_r        <= off_nxt;
      tok_start_r  <= tok_start_nxt;
      line_r       <= line_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_kind_r  <= pend_kind_nxt;
    pend_start_r <= pend_start_nxt;
    pend_len_r   <= pend_len_nxt;
    pend_line_r  <= pend_line_nxt;
    out_kind_r   <= out_kind_nxt;
    out_start_r  <= out_start_nxt;
    out_len_r    <= out_len_nxt;
    out_line_r   <= out_line_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_start_pos   = out_start_r;
  assign out_length      = out_len_r;
  assign out_line        = out_line_r;
  assign out_last_of_run = out_last_r;

endmodule

/* hdl/dlmt_step.sv */
// ============================================================================
// dlmt_step
// One scanner step: classifies a byte by priority and looks up the transition.
// ============================================================================
module dlmt_step (
  input  dlmt_pkg::dfa_state_t            cur_state,
  input  logic [dlmt_pkg::CH_W-1:0]       ch,
  output dlmt_pkg::step_res_t             res
);

  logic               is_alpha;
  logic               is_digit;
  logic               is_e;
  logic               is_at;
  logic               is_blank;
  logic               any_class;
  dlmt_pkg::dfa_state_t ns;

  // Character classes.
  assign is_alpha = (ch >= dlmt_pkg::CH_LOW_A) && (ch <= dlmt_pkg::CH_LOW_Z);
  assign is_digit = (ch >= dlmt_pkg::CH_DIGIT_0) && (ch <= dlmt_pkg::CH_DIGIT_9);
  assign is_e     = (ch == dlmt_pkg::CH_LOW_E);
  assign is_at    = (ch == dlmt_pkg::CH_AT);
  assign is_blank = (ch == dlmt_pkg::CH_SPACE) || (ch == dlmt_pkg::CH_NEWLINE) ||
                    (ch == dlmt_pkg::CH_TAB) || (ch == dlmt_pkg::CH_BACKSPACE);
  assign any_class = is_alpha || is_digit || is_e || is_at || is_blank;

  // Take the first class, in priority order, that has a live transition.
  // Literal rows only apply when the byte is in no class at all.
  always_comb begin
    ns = dlmt_pkg::ST_DEAD;
    if (cur_state <= dlmt_pkg::ST_LAST) begin
      if (is_alpha && ns == dlmt_pkg::ST_DEAD) begin
        ns = dlmt_pkg::TRANS[dlmt_pkg::ROW_ALPHA][cur_state];
      end
      if (is_digit && ns == dlmt_pkg::ST_DEAD) begin
        ns = dlmt_pkg::TRANS[dlmt_pkg::ROW_DIGIT][cur_state];
      end
      if (is_e && ns == dlmt_pkg::ST_DEAD) begin
        ns = dlmt_pkg::TRANS[dlmt_pkg::ROW_E][cur_state];
      end
      if (is_at && ns == dlmt_pkg::ST_DEAD) begin
        ns = dlmt_pkg::TRANS[dlmt_pkg::ROW_AT][cur_state];
      end
      if (is_blank && ns == dlmt_pkg::ST_DEAD) begin
        ns = dlmt_pkg::TRANS[dlmt_pkg::ROW_BLANK][cur_state];
      end
      if (!any_class && ch == dlmt_pkg::CH_DOT) begin
        ns = dlmt_pkg::TRANS[dlmt_pkg::ROW_DOT][cur_state];
      end
      if (!any_class && ch == dlmt_pkg::CH_UNDER) begin
        ns = dlmt_pkg::TRANS[dlmt_pkg::ROW_UNDER][cur_state];
      end
    end
  end

  assign res.nxt_state  = ns;
  assign res.dead       = (ns == dlmt_pkg::ST_DEAD);
  assign res.accepting  = (dlmt_pkg::accept_kind_of(ns) != dlmt_pkg::NO_KIND);
  assign res.is_newline = (ch == dlmt_pkg::CH_NEWLINE);

endmodule

/* tb/tb_dfa_longest_match_tokenizer.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_dfa_longest_match_tokenizer
// Self-checking bench for the longest-match tokenizer. A table of directed
// bytes comes first: lone characters, byte extremes, every token kind, a
// rewind and a flush. Random text follows, built from number, identifier,
// blank and at-sign fragments mixed with noise and broken prefixes. Two long
// runs force full-buffer decisions. A built-in scanner predicts all other tokens.
// ============================================================================
module tb_dfa_longest_match_tokenizer;

  localparam int N_DIRECTED   = 25;
  localparam int RANDOM_BYTES = 240;
  localparam int MAX_PER_BYTE = 64;
  localparam int DEPTH        = dlmt_pkg::LOOKAHEAD_DEPTH;
  localparam dlmt_pkg::dfa_state_t XX = dlmt_pkg::ST_DEAD;

  typedef logic [dlmt_pkg::CH_W-1:0]  ch_t;
  typedef logic [dlmt_pkg::POS_W-1:0] pos_t;

  typedef struct packed {
    dlmt_pkg::kind_t               kind;
    pos_t                          start;
    logic [dlmt_pkg::LEN_W-1:0]    len;
    pos_t                          line;
    logic                          last;
  } token_t;

  typedef struct {
    ch_t             ch;
    logic            eot;
    bit              known;
    token_t          tok;
  } stim_row_t;

  typedef ch_t text_q_t [$];

  // Scanner transitions, one row per character class.
  localparam dlmt_pkg::dfa_state_t NEXT_STATE [dlmt_pkg::NUM_ROWS][dlmt_pkg::NUM_STATES] = '{
    '{4'd7, XX,   XX,   XX, XX,   XX,   XX,   4'd7, XX},
    '{4'd1, 4'd1, 4'd2, 4'd2, 4'd5, 4'd5, XX, 4'd7, XX},
    '{XX,   4'd4, 4'd4, XX, XX,   XX,   XX,   XX,   XX},
    '{4'd3, 4'd2, XX,   XX, XX,   XX,   XX,   XX,   XX},
    '{4'd8, XX,   XX,   XX, XX,   XX,   XX,   XX,   XX},
    '{4'd6, XX,   XX,   XX, XX,   XX,   4'd6, XX,   XX},
    '{4'd7, XX,   XX,   XX, XX,   XX,   XX,   4'd7, XX}
  };

  localparam dlmt_pkg::kind_t STATE_KIND [dlmt_pkg::NUM_STATES] = '{
    dlmt_pkg::NO_KIND, dlmt_pkg::KIND_NUMBER, dlmt_pkg::KIND_NUMBER,
    dlmt_pkg::NO_KIND, dlmt_pkg::NO_KIND, dlmt_pkg::KIND_NUMBER,
    dlmt_pkg::KIND_SPACE, dlmt_pkg::KIND_IDENT, dlmt_pkg::KIND_AT
  };

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  ch_t                   in_ch          = '0;
  logic                  in_end_of_text = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  dlmt_pkg::kind_t       out_kind;
  pos_t                  out_start_pos;
  logic [dlmt_pkg::LEN_W-1:0] out_length;
  pos_t                  out_line;
  logic                  out_last_of_run;

  // Predictor state.
  dlmt_pkg::dfa_state_t  scan_st;
  dlmt_pkg::dfa_state_t  match_st;
  pos_t                  match_end;
  pos_t                  tok_start;
  pos_t                  cursor;
  pos_t                  bytes_in;
  pos_t                  line_no;
  ch_t                   held [DEPTH];

  token_t                step_tokens [$];
  token_t                tokens_due [$];
  int                    bytes_sent = 0;
  int                    mismatches = 0;
  bit                    hold_rx    = 1'b0;

  // Directed bytes. Lone characters closed by end of text have known tokens.
  stim_row_t directed [N_DIRECTED] = '{
    '{dlmt_pkg::CH_AT, 1'b1, 1'b1,
      '{dlmt_pkg::KIND_AT, 32'd0, 7'd1, 32'd0, 1'b1}},
    '{"A", 1'b1, 1'b1, '{dlmt_pkg::KIND_UNMATCHED, 32'd0, 7'd1, 32'd0, 1'b1}},
    '{8'h00, 1'b1, 1'b1, '{dlmt_pkg::KIND_UNMATCHED, 32'd0, 7'd1, 32'd0, 1'b1}},
    '{8'hFF, 1'b1, 1'b1, '{dlmt_pkg::KIND_UNMATCHED, 32'd0, 7'd1, 32'd0, 1'b1}},
    '{dlmt_pkg::CH_UNDER, 1'b1, 1'b1,
      '{dlmt_pkg::KIND_IDENT, 32'd0, 7'd1, 32'd0, 1'b1}},
    '{dlmt_pkg::CH_DOT, 1'b1, 1'b1,
      '{dlmt_pkg::KIND_UNMATCHED, 32'd0, 7'd1, 32'd0, 1'b1}},
    '{"1",                    1'b0, 1'b0, '0},
    '{"2",                    1'b0, 1'b0, '0},
    '{dlmt_pkg::CH_DOT,       1'b0, 1'b0, '0},
    '{"5",                    1'b0, 1'b0, '0},
    '{dlmt_pkg::CH_LOW_E,     1'b0, 1'b0, '0},
    '{"3",                    1'b0, 1'b0, '0},
    '{dlmt_pkg::CH_SPACE,     1'b0, 1'b0, '0},
    '{dlmt_pkg::CH_NEWLINE,   1'b0, 1'b0, '0},
    '{"a",                    1'b0, 1'b0, '0},
    '{dlmt_pkg::CH_UNDER,     1'b0, 1'b0, '0},
    '{dlmt_pkg::CH_LOW_Z,     1'b0, 1'b0, '0},
    '{dlmt_pkg::CH_TAB,       1'b0, 1'b0, '0},
    '{dlmt_pkg::CH_BACKSPACE, 1'b0, 1'b0, '0},
    '{"1",                    1'b0, 1'b0, '0},
    '{dlmt_pkg::CH_LOW_E,     1'b0, 1'b0, '0},
    '{"x",                    1'b0, 1'b0, '0},
    '{"7",                    1'b0, 1'b0, '0},
    '{dlmt_pkg::CH_DOT,       1'b0, 1'b0, '0},
    '{dlmt_pkg::CH_LOW_E,     1'b1, 1'b0, '0}
  };

  dfa_longest_match_tokenizer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_start_pos   (out_start_pos),
    .out_length      (out_length),
    .out_line        (out_line),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("tb_dfa_longest_match_tokenizer: done, errors");
    $finish;
  end

  // One scanner step: tries the classes in priority order.
  function automatic dlmt_pkg::dfa_state_t advance(input dlmt_pkg::dfa_state_t st,
                                                   input ch_t c);
    int unsigned          rows [6];
    int                   nr;
    dlmt_pkg::dfa_state_t ns;
    nr = 0;
    ns = XX;
    if (c >= dlmt_pkg::CH_LOW_A && c <= dlmt_pkg::CH_LOW_Z) begin
      rows[nr] = dlmt_pkg::ROW_ALPHA;
      nr++;
    end
    if (c >= dlmt_pkg::CH_DIGIT_0 && c <= dlmt_pkg::CH_DIGIT_9) begin
      rows[nr] = dlmt_pkg::ROW_DIGIT;
      nr++;
    end
    if (c == dlmt_pkg::CH_LOW_E) begin
      rows[nr] = dlmt_pkg::ROW_E;
      nr++;
    end
    if (c == dlmt_pkg::CH_AT) begin
      rows[nr] = dlmt_pkg::ROW_AT;
      nr++;
    end
    if (c == dlmt_pkg::CH_SPACE || c == dlmt_pkg::CH_NEWLINE ||
        c == dlmt_pkg::CH_TAB || c == dlmt_pkg::CH_BACKSPACE) begin
      rows[nr] = dlmt_pkg::ROW_BLANK;
      nr++;
    end
    if (nr == 0 && c == dlmt_pkg::CH_DOT) begin
      rows[nr] = dlmt_pkg::ROW_DOT;
      nr++;
    end else if (nr == 0 && c == dlmt_pkg::CH_UNDER) begin
      rows[nr] = dlmt_pkg::ROW_UNDER;
      nr++;
    end
    if (st <= dlmt_pkg::ST_LAST) begin
      for (int i = 0; i < nr; i++) begin
        if (ns == XX) ns = NEXT_STATE[rows[i]][st];
      end
    end
    return ns;
  endfunction

  // Emits one token, drops its bytes from the buffer and restarts the scanner.
  function automatic void emit_token(input dlmt_pkg::kind_t k, input pos_t len);
    token_t t;
    pos_t   occ;
    occ = bytes_in - tok_start;
    if (len > occ) len = occ;
    t.kind  = k;
    t.start = tok_start;
    t.len   = len[dlmt_pkg::LEN_W-1:0];
    t.line  = line_no;
    t.last  = 1'b0;
    step_tokens = {step_tokens, t};
    for (int i = 0; i < len; i++) begin
      if (held[i] == dlmt_pkg::CH_NEWLINE) line_no++;
    end
    for (int i = 0; i < occ - len; i++) held[i] = held[i + len];
    tok_start += len;
    cursor    = tok_start;
    match_end = tok_start;
    match_st  = dlmt_pkg::NO_ACCEPT;
    scan_st   = dlmt_pkg::ST_START;
  endfunction

  // Longest accepted prefix, or the first byte as unmatched.
  function automatic void decide_token();
    if (match_st <= dlmt_pkg::ST_LAST && STATE_KIND[match_st] != dlmt_pkg::NO_KIND) begin
      emit_token(STATE_KIND[match_st], match_end - tok_start);
    end else begin
      emit_token(dlmt_pkg::KIND_UNMATCHED, 32'd1);
    end
  endfunction

  // Scans the buffered bytes until more input is needed.
  function automatic void scan_held(input bit flush);
    pos_t                 occ;
    pos_t                 off;
    dlmt_pkg::dfa_state_t ns;
    while (step_tokens.size() < MAX_PER_BYTE) begin
      occ = bytes_in - tok_start;
      off = cursor - tok_start;
      if (off < occ && off < DEPTH) begin
        ns = advance(scan_st, held[off]);
        if (ns == XX) begin
          decide_token();
        end else begin
          scan_st = ns;
          cursor++;
          if (STATE_KIND[ns] != dlmt_pkg::NO_KIND) begin
            match_st  = ns;
            match_end = cursor;
          end
        end
      end else if (occ == 0) begin
        break;
      end else if (flush || occ >= DEPTH) begin
        decide_token();
      end else begin
        break;
      end
    end
  endfunction

  function automatic void clear_scanner();
    scan_st   = dlmt_pkg::ST_START;
    match_st  = dlmt_pkg::NO_ACCEPT;
    match_end = '0;
    tok_start = '0;
    cursor    = '0;
    bytes_in  = '0;
    line_no   = '0;
  endfunction

  // Tokens caused by one accepted byte land in step_tokens.
  function automatic void tokenize_byte(input ch_t c, input logic eot);
    pos_t occ;
    step_tokens.delete();
    scan_held(1'b0);
    occ = bytes_in - tok_start;
    if (occ < DEPTH) begin
      held[occ] = c;
      bytes_in++;
    end
    scan_held(eot);
    if (eot && bytes_in == tok_start) clear_scanner();
    if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
  endfunction

  // Random idling is off for a stretch in the middle of the run.
  function automatic bit gaps_on();
    return !(bytes_sent >= 160 && bytes_sent < 230);
  endfunction

  function automatic ch_t pick_blank();
    ch_t blanks [4];
    blanks = '{dlmt_pkg::CH_SPACE, dlmt_pkg::CH_NEWLINE, dlmt_pkg::CH_TAB,
               dlmt_pkg::CH_BACKSPACE};
    return blanks[$urandom_range(0, 3)];
  endfunction

  function automatic ch_t digit();
    return dlmt_pkg::CH_DIGIT_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic ch_t letter();
    return dlmt_pkg::CH_LOW_A + 8'($urandom_range(0, 25));
  endfunction

  // Offers one request and waits for it to be taken; starts and ends at a
  // falling edge.
  task automatic send_byte(input ch_t c, input logic eot, input bit known,
                           input token_t tok);
    while (gaps_on() && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_ch          <= c;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_byte(c, eot);
    if (known) begin
      tokens_due = {tokens_due, tok};
    end else begin
      foreach (step_tokens[i]) tokens_due = {tokens_due, step_tokens[i]};
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stimulus: reset, directed table, then random text.
  initial begin : stimulus
    text_q_t     frag;
    bit          eot;
    bit          long_word_done;
    bit          long_blank_done;
    int unsigned pick;
    long_word_done  = 1'b0;
    long_blank_done = 1'b0;
    clear_scanner();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_byte(directed[i].ch, directed[i].eot, directed[i].known, directed[i].tok);
    end

    while (bytes_sent < N_DIRECTED + RANDOM_BYTES) begin
      frag = {};
      pick = $urandom_range(0, 99);
      if (!long_word_done && bytes_sent >= 50) begin
        // Identifier longer than the buffer forces a decision when full.
        repeat (70) frag = {frag, letter()};
        long_word_done = 1'b1;
      end else if (!long_blank_done && bytes_sent >= 200) begin
        repeat (68) frag = {frag, pick_blank()};
        long_blank_done = 1'b1;
      end else if (pick < 30) begin
        // Number with optional fraction and exponent, sometimes cut short.
        repeat ($urandom_range(1, 4)) frag = {frag, digit()};
        if ($urandom_range(0, 99) < 40) begin
          frag = {frag, dlmt_pkg::CH_DOT};
          repeat ($urandom_range(0, 3)) frag = {frag, digit()};
        end
        if ($urandom_range(0, 99) < 30) begin
          frag = {frag, dlmt_pkg::CH_LOW_E};
          repeat ($urandom_range(0, 2)) frag = {frag, digit()};
        end
      end else if (pick < 58) begin
        repeat ($urandom_range(1, 6)) begin
          frag = {frag, (($urandom_range(0, 5) == 0) ? dlmt_pkg::CH_UNDER : letter())};
        end
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 3)) frag = {frag, pick_blank()};
      end else if (pick < 80) begin
        frag = {frag, dlmt_pkg::CH_AT};
      end else if (pick < 90) begin
        // Noise: any byte, or an uppercase letter.
        if ($urandom_range(0, 1) == 0) frag = {frag, ch_t'($urandom_range(0, 255))};
        else frag = {frag, ch_t'("A" + 8'($urandom_range(0, 25)))};
      end else begin
        // Broken prefixes that make the scanner rewind.
        case ($urandom_range(0, 3))
          0: frag = {frag, dlmt_pkg::CH_DOT};
          1: begin
            frag = {frag, dlmt_pkg::CH_DOT};
            frag = {frag, digit()};
          end
          2: begin
            frag = {frag, digit()};
            frag = {frag, dlmt_pkg::CH_LOW_E};
            frag = {frag, letter()};
          end
          default: begin
            frag = {frag, digit()};
            frag = {frag, dlmt_pkg::CH_DOT};
            frag = {frag, dlmt_pkg::CH_LOW_E};
            frag = {frag, pick_blank()};
          end
        endcase
      end
      eot = ($urandom_range(0, 99) < 6);
      foreach (frag[i]) send_byte(frag[i], eot && (i == frag.size() - 1), 1'b0, '0);
    end

    // Close the text so every buffered byte is decided.
    send_byte(dlmt_pkg::CH_SPACE, 1'b1, 1'b0, '0);
    in_valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_dfa_longest_match_tokenizer: done, clean");
    end else begin
      $display("tb_dfa_longest_match_tokenizer: done, errors");
    end
    $finish;
  end

  // Long output hold-off while the sender keeps offering bytes.
  initial begin : rx_hold
    wait (bytes_sent >= 90);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;
  end

  // Receiver stall.
  initial begin : rx_side
    forever begin
      @(negedge clk);
      out_stall <= hold_rx || (gaps_on() && $urandom_range(0, 99) < 14);
    end
  end

  // Compare each accepted token with the oldest prediction.
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected token: kind %0d start %0d len %0d line %0d last %0d",
                   out_kind, out_start_pos, out_length, out_line, out_last_of_run);
        end
      end else begin
        want = tokens_due.pop_front();
        if (out_kind !== want.kind || out_start_pos !== want.start ||
            out_length !== want.len || out_line !== want.line ||
            out_last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("token mismatch: want kind %0d start %0d len %0d line %0d last %0d",
                     want.kind, want.start, want.len, want.line, want.last);
            $display("                got  kind %0d start %0d len %0d line %0d last %0d",
                     out_kind, out_start_pos, out_length, out_line, out_last_of_run);
          end
        end
      end
    end
  end

endmodule
